// File: rtl/vn_pkg.sv
// Package for the three-component vector normalizer.
// Holds the sideband type that travels with each request down the cell chain.
package vn_pkg;

  // Per-request sideband: occupancy, zero-vector flag and component signs.
  typedef struct packed {
    logic       vld;
    logic       zero;
    logic [2:0] neg;
  } vn_side_t;

endpackage

// File: rtl/vn_sqrt_cell.sv
// One digit cell of the restoring square-root chain.
// Depends on vn_pkg for the sideband type.
module vn_sqrt_cell #(
  parameter int LEN_W  = 32,
  parameter int PASS_W = 96
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  vn_pkg::vn_side_t     side_i,
  input  logic [2*LEN_W-1:0]   rad_i,
  input  logic [LEN_W+2:0]     rem_i,
  input  logic [LEN_W-1:0]     root_i,
  input  logic [PASS_W-1:0]    pass_i,
  output vn_pkg::vn_side_t     side_o,
  output logic [2*LEN_W-1:0]   rad_o,
  output logic [LEN_W+2:0]     rem_o,
  output logic [LEN_W-1:0]     root_o,
  output logic [PASS_W-1:0]    pass_o
);

  logic [LEN_W+2:0] rem_sh;
  logic [LEN_W+2:0] trial;
  logic             take;

  vn_pkg::vn_side_t   side_r;
  logic [2*LEN_W-1:0] rad_r;
  logic [LEN_W+2:0]   rem_r;
  logic [LEN_W-1:0]   root_r;
  logic [PASS_W-1:0]  pass_r;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_sh = {rem_i[LEN_W:0], rad_i[2*LEN_W-1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (adv) begin
      side_r <= side_i;
      rad_r  <= {rad_i[2*LEN_W-3:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_i[LEN_W-2:0], take};
      pass_r <= pass_i;
    end
  end

  assign side_o = side_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pass_o = pass_r;

endmodule

// File: rtl/vn_div_cell.sv
// One quotient-bit cell of the three-lane restoring divider chain.
// Depends on vn_pkg for the sideband type.
module vn_div_cell #(
  parameter int LEN_W = 32,
  parameter int Q_W   = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  vn_pkg::vn_side_t     side_i,
  input  logic [LEN_W-1:0]     len_i,
  input  logic [3*(LEN_W+1)-1:0] rem_i,
  input  logic [3*Q_W-1:0]     q_i,
  output vn_pkg::vn_side_t     side_o,
  output logic [LEN_W-1:0]     len_o,
  output logic [3*(LEN_W+1)-1:0] rem_o,
  output logic [3*Q_W-1:0]     q_o
);

  localparam int RW = LEN_W + 1;

  logic [3*RW-1:0]  rem_nxt;
  logic [3*Q_W-1:0] q_nxt;

  vn_pkg::vn_side_t   side_r;
  logic [LEN_W-1:0]   len_r;
  logic [3*RW-1:0]    rem_r;
  logic [3*Q_W-1:0]   q_r;

  always_comb begin
    logic [RW:0]   diff;
    logic [RW-1:0] keep;
    for (int k = 0; k < 3; k++) begin
      diff = {1'b0, rem_i[k*RW +: RW]} - {2'b00, len_i};
      keep = diff[RW] ? rem_i[k*RW +: RW] : diff[RW-1:0];
      rem_nxt[k*RW +: RW] = {keep[RW-2:0], 1'b0};
      q_nxt[k*Q_W +: Q_W] = {q_i[k*Q_W +: Q_W-1], ~diff[RW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (adv) begin
      side_r <= side_i;
      len_r  <= len_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
    end
  end

  assign side_o = side_r;
  assign len_o  = len_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;

endmodule

// File: rtl/vector3_normalize_top.sv
// Top level of the three-component vector normalizer.
// Depends on vn_pkg, vn_sqrt_cell and vn_div_cell.
//
// Usage: present a vector on in_comp_x/y/z with in_valid; it is taken when
// in_ready is also high. One result request appears on out_unit_x/y/z,
// out_vec_length and out_is_zero with out_valid and is taken with out_ready.
// The length is floor(sqrt(x^2+y^2+z^2)) in the input format and each unit
// component is |c|*2^UNIT_FRAC_BITS/length truncated toward zero, signed.
// A zero vector gives zero components, zero length and out_is_zero high.
//
// The pipeline is made of magnitude, square and sum stages, one cell per root
// bit, one cell per quotient bit, and the output register. Throughput is one
// vector per cycle while the receiver does not stall; every cell is its own
// pipeline stage, so a new request enters each cycle the chain advances.
// When the receiver stalls with a result held, the whole chain holds and
// in_ready drops in the same cycle. Reset (synchronous, active low) empties
// the chain and the output register; no other state exists.
module vector3_normalize_top #(
  parameter int COMP_WIDTH     = 32,
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COMP_WIDTH-1:0] in_comp_x,
  input  logic signed [COMP_WIDTH-1:0] in_comp_y,
  input  logic signed [COMP_WIDTH-1:0] in_comp_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [UNIT_FRAC_BITS+1:0] out_unit_x,
  output logic signed [UNIT_FRAC_BITS+1:0] out_unit_y,
  output logic signed [UNIT_FRAC_BITS+1:0] out_unit_z,
  output logic [COMP_WIDTH-1:0]        out_vec_length,
  output logic                         out_is_zero
);

  localparam int CW  = COMP_WIDTH;
  localparam int UW  = UNIT_FRAC_BITS + 2;
  localparam int QW  = UNIT_FRAC_BITS + 1;
  localparam int SW  = 2 * CW;          // squares and their sum
  localparam int RW  = CW + 3;          // root remainder width
  localparam int NSQ = CW;              // root bits, one cell each
  localparam int NDV = QW;              // quotient bits, one cell each

  // The chain advances whenever the output register is free or being read.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: magnitudes and signs.
  vn_pkg::vn_side_t s1_side_r;
  logic [3*CW-1:0]  s1_mag_r;
  logic [3*CW-1:0]  mag_nxt;
  logic [2:0]       neg_nxt;

  always_comb begin
    logic [CW-1:0] c [3];
    c[0] = in_comp_x;
    c[1] = in_comp_y;
    c[2] = in_comp_z;
    for (int k = 0; k < 3; k++) begin
      neg_nxt[k]           = c[k][CW-1];
      mag_nxt[k*CW +: CW]  = c[k][CW-1] ? (~c[k] + 1'b1) : c[k];
    end
  end

  // Stage 2: squares. Stage 3: sum of squares.
  vn_pkg::vn_side_t s2_side_r, s3_side_r;
  logic [3*CW-1:0]  s2_mag_r, s3_mag_r;
  logic [SW-1:0]    s2_sq_r [3];
  logic [SW-1:0]    s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
      s2_side_r.vld <= 1'b0;
      s3_side_r.vld <= 1'b0;
    end else if (adv) begin
      s1_side_r.vld  <= in_valid;
      s1_side_r.neg  <= neg_nxt;
      s1_side_r.zero <= (mag_nxt == '0);
      s1_mag_r       <= mag_nxt;
      s2_side_r      <= s1_side_r;
      s2_mag_r       <= s1_mag_r;
      for (int k = 0; k < 3; k++) begin
        s2_sq_r[k] <= SW'(s1_mag_r[k*CW +: CW]) * SW'(s1_mag_r[k*CW +: CW]);
      end
      s3_side_r      <= s2_side_r;
      s3_mag_r       <= s2_mag_r;
      s3_sum_r       <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  // Square-root chain: one cell per result bit, magnitudes ride along.
  vn_pkg::vn_side_t sq_side [NSQ+1];
  logic [SW-1:0]    sq_rad  [NSQ+1];
  logic [RW-1:0]    sq_rem  [NSQ+1];
  logic [CW-1:0]    sq_root [NSQ+1];
  logic [3*CW-1:0]  sq_pass [NSQ+1];

  assign sq_side[0] = s3_side_r;
  assign sq_rad[0]  = s3_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pass[0] = s3_mag_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    vn_sqrt_cell #(.LEN_W(CW), .PASS_W(3*CW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (sq_side[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .pass_i (sq_pass[i]),
      .side_o (sq_side[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .pass_o (sq_pass[i+1])
    );
  end

  // Divider chain: three lanes share the length, one quotient bit per cell.
  // The magnitude never exceeds the length, so the first partial remainder
  // is the magnitude itself and the quotient fits UNIT_FRAC_BITS+1 bits.
  vn_pkg::vn_side_t   dv_side [NDV+1];
  logic [CW-1:0]      dv_len  [NDV+1];
  logic [3*(CW+1)-1:0] dv_rem [NDV+1];
  logic [3*QW-1:0]    dv_q    [NDV+1];

  assign dv_side[0] = sq_side[NSQ];
  assign dv_len[0]  = sq_root[NSQ];
  assign dv_q[0]    = '0;
  for (genvar k = 0; k < 3; k++) begin : g_rem0
    assign dv_rem[0][k*(CW+1) +: CW+1] = {1'b0, sq_pass[NSQ][k*CW +: CW]};
  end

  for (genvar i = 0; i < NDV; i++) begin : g_div
    vn_div_cell #(.LEN_W(CW), .Q_W(QW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .side_i (dv_side[i]),
      .len_i  (dv_len[i]),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .side_o (dv_side[i+1]),
      .len_o  (dv_len[i+1]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1])
    );
  end

  // Output register: apply signs, force the zero-vector result.
  vn_pkg::vn_side_t last;
  logic [UW-1:0]    unit_nxt [3];
  logic             out_valid_r;
  logic [UW-1:0]    unit_r [3];
  logic [CW-1:0]    len_r;
  logic             zero_r;

  assign last = dv_side[NDV];

  always_comb begin
    logic [UW-1:0] qx;
    for (int k = 0; k < 3; k++) begin
      qx = {1'b0, dv_q[NDV][k*QW +: QW]};
      if (last.zero) begin
        unit_nxt[k] = '0;
      end else begin
        unit_nxt[k] = last.neg[k] ? (~qx + 1'b1) : qx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r[0] <= unit_nxt[0];
      unit_r[1] <= unit_nxt[1];
      unit_r[2] <= unit_nxt[2];
      len_r     <= last.zero ? '0 : dv_len[NDV];
      zero_r    <= last.zero;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_unit_x     = unit_r[0];
  assign out_unit_y     = unit_r[1];
  assign out_unit_z     = unit_r[2];
  assign out_vec_length = len_r;
  assign out_is_zero    = zero_r;

  // A zero-vector result carries zero length and a zero x component.
  a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_zero) |-> (out_vec_length == '0 && out_unit_x == '0))
    else $error("zero vector result with nonzero payload");

  // A nonzero vector always has a nonzero length.
  a_nonzero_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_zero) |-> (out_vec_length != '0))
    else $error("nonzero vector with zero length");

  // The chain holds whenever a result waits for the receiver.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
